// ----- sv/nqueens_annealing_swap_engine_macros.svh -----
// Assertion macros shared by the annealing swap engine RTL.
`ifndef NQUEENS_ANNEALING_SWAP_ENGINE_MACROS_SVH
`define NQUEENS_ANNEALING_SWAP_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define NQAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define NQAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nqas_pkg.sv -----
// Shared types, constants and the log table builder for the annealing swap engine.
`default_nettype none

package nqas_pkg;

  localparam int ACTION_W    = 2;
  localparam int ROW_W       = 6;
  localparam int SAMPLE_W    = 10;
  localparam int COST_W      = 13;
  localparam int COL_W       = 6;
  localparam int BOARD_W     = 7;
  localparam int TEMP_W      = 32;
  localparam int COOL_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_BOARD_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_TEMP  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLING     = 2'd2;

  localparam logic [BOARD_W-1:0] BOARD_SIZE_RESET = 7'd8;
  localparam logic [TEMP_W-1:0]  START_TEMP_RESET = 32'd65536000;
  localparam logic [COOL_W-1:0]  COOLING_RESET    = 16'd64881;

  localparam logic [COST_W-1:0]   COST_SAT   = 13'd8191;
  localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = 10'd1000;

  // Magnitude of ln(sample / 1000) in Q3.16, one entry per sample code.
  localparam int          LN_W     = 19;
  localparam int          LN_DEPTH = 1024;
  localparam logic [63:0] LN2_Q30  = 64'd744261118;

  typedef logic [LN_W-1:0] ln_rom_t [LN_DEPTH];

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_COLA,
    ST_COLB,
    ST_CAPB,
    ST_OPRD,
    ST_OPWR,
    ST_MUL,
    ST_DECIDE,
    ST_WRA,
    ST_WRB,
    ST_ROWRD,
    ST_ROWCAP,
    ST_DONE
  } state_e;

  // Builds the log table at elaboration: long division by shift and subtract,
  // then thirty squaring steps that peel off the fraction bits of log2.
  function automatic ln_rom_t build_ln_rom();
    ln_rom_t     rom;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] v;
    logic [63:0] frac;
    logic [63:0] l2;
    logic [63:0] prod;
    int          k;
    for (int s = 0; s < LN_DEPTH; s++) begin
      rom[s] = '0;
      if (s >= 1 && s <= 999) begin
        k = 0;
        for (int j = 0; j < 10; j++) begin
          if ((64'(s) << (k + 1)) <= 64'd1000) k++;
        end
        num = 64'd1000 << 30;
        den = 64'(s) << k;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
          rem = {rem[62:0], num[i]};
          if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
          end
        end
        v    = quo;
        frac = '0;
        for (int i = 29; i >= 0; i--) begin
          v = (v * v) >> 30;
          if (v >= (64'd2 << 30)) begin
            v       = v >> 1;
            frac[i] = 1'b1;
          end
        end
        l2     = (64'(k) << 30) | frac;
        prod   = l2 * LN2_Q30;
        rom[s] = LN_W'((prod + (64'd1 << 43)) >> 44);
      end
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- sv/nqas_in_if.sv -----
// Input channel of the annealing swap engine: valid, ready and one work item.
`default_nettype none

interface nqas_in_if;
  import nqas_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ROW_W-1:0]    first_row;
  logic [ROW_W-1:0]    second_row;
  logic [SAMPLE_W-1:0] random_sample;

  modport source (output valid, action, first_row, second_row, random_sample, input ready);
  modport sink   (input valid, action, first_row, second_row, random_sample, output ready);
endinterface

`default_nettype wire

// ----- sv/nqas_out_if.sv -----
// Result channel of the annealing swap engine: valid, ready and one result.
`default_nettype none

interface nqas_out_if;
  import nqas_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              accepted;
  logic              skipped;
  logic              solved;
  logic [COL_W-1:0]  column;

  modport source (output valid, cost, accepted, skipped, solved, column, input ready);
  modport sink   (input valid, cost, accepted, skipped, solved, column, output ready);
endinterface

`default_nettype wire

// ----- sv/nqueens_annealing_swap_engine.sv -----
// Top level of the N-queens simulated annealing swap engine.
`default_nettype none

// The engine holds a queen permutation, one column per row, in a column memory
// and the number of queens on every diagonal of both families in two counter
// memories, all with registered reads. A start item rewrites the identity
// permutation and the counters in one sweep over the 2*MAX_QUEENS diagonal
// addresses and loads the temperature. A move item reads both columns, then
// lifts and places the two queens through the counter memories, with a read
// state and a write state per step, so the cost changes incrementally; a
// multiply state and a decide state apply the annealing test and cooling, and
// a kept move writes the two swapped columns back while a rejected move
// replays the four counter steps to undo itself.
// After reset the same sweep runs once before the first item is taken;
// configuration writes are taken at any time. One item is in work at a time;
// a finished result waits in the done state until the output register is free
// or being emptied, and the next item is taken once it has moved into that
// register.
module nqueens_annealing_swap_engine #(
  parameter int MAX_QUEENS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  nqas_in_if.sink                              in_ch,
  nqas_out_if.source                           out_ch,
  input  logic                                 cfg_we_i,
  input  logic [nqas_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [nqas_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import nqas_pkg::*;

  localparam int RowW     = $clog2(MAX_QUEENS);
  localparam int DiagW    = $clog2(2 * MAX_QUEENS);
  localparam int CntW     = $clog2(MAX_QUEENS + 1);
  localparam int ActW     = CntW;
  localparam int SweepW   = DiagW + 1;
  localparam int CostW    = $clog2(2 * MAX_QUEENS * (MAX_QUEENS - 1) + 1);
  localparam int CostExtW = (CostW > COST_W) ? CostW : COST_W;
  localparam int RowExtW  = (RowW > ROW_W) ? RowW : ROW_W;
  localparam int ColExtW  = (RowW > COL_W) ? RowW : COL_W;
  localparam int CmpW     = (ActW > ROW_W) ? ActW : ROW_W;
  localparam int BsW      = (ActW > BOARD_W) ? ActW : BOARD_W;
  localparam int ActReset = (MAX_QUEENS < 8) ? MAX_QUEENS : 8;
  localparam int PrW      = TEMP_W + LN_W;
  localparam int CoolPrW  = TEMP_W + COOL_W;

  localparam ln_rom_t LnRom = build_ln_rom();

  // Configuration registers.
  logic [BOARD_W-1:0] board_size_q;
  logic [TEMP_W-1:0]  start_temp_q;
  logic [COOL_W-1:0]  cooling_q;

  // Control state.
  state_e              state_q, state_d;
  logic [SweepW-1:0]   sweep_q;
  logic                start_flag_q;
  logic                loaded_q;
  logic                solved_q;
  logic [ActW-1:0]     act_q;
  logic [CostW-1:0]    cost_q;
  logic [TEMP_W-1:0]   temp_q;
  logic [1:0]          op_q;
  logic                undo_q;
  logic                res_valid_q;

  // Item payload and work registers.
  logic [ROW_W-1:0]    a_q;
  logic [ROW_W-1:0]    b_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                rd_ok_q;
  logic [RowW-1:0]     ca_q;
  logic [RowW-1:0]     cb_q;
  logic [DiagW-1:0]    li_q;
  logic [DiagW-1:0]    ri_q;
  logic [CostW-1:0]    work_cost_q;
  logic [LN_W-1:0]     ln_q;
  logic [PrW-1:0]      prod_q;
  logic [CoolPrW-1:0]  cool_q;
  logic                acc_q;
  logic                skip_q;
  logic [RowW-1:0]     col_res_q;

  // Output register.
  logic [COST_W-1:0]   res_cost_q;
  logic                res_acc_q;
  logic                res_skip_q;
  logic                res_solved_q;
  logic [RowW-1:0]     res_col_q;

  // Memories and their ports.
  logic [RowW-1:0] col_mem [MAX_QUEENS];
  logic [CntW-1:0] ld_mem  [2 * MAX_QUEENS];
  logic [CntW-1:0] rd_mem  [2 * MAX_QUEENS];

  logic            col_we;
  logic [RowW-1:0] col_waddr;
  logic [RowW-1:0] col_wdata;
  logic [RowW-1:0] col_raddr;
  logic [RowW-1:0] col_rd_q;

  logic             ld_we;
  logic [DiagW-1:0] ld_waddr;
  logic [CntW-1:0]  ld_wdata;
  logic [DiagW-1:0] ld_raddr;
  logic [CntW-1:0]  ld_rd_q;

  logic             rd_we;
  logic [DiagW-1:0] rd_waddr;
  logic [CntW-1:0]  rd_wdata;
  logic [DiagW-1:0] rd_raddr;
  logic [CntW-1:0]  rd_rd_q;

  // Derived values.
  logic [RowExtW-1:0] a_ext;
  logic [RowExtW-1:0] b_ext;
  logic [RowW-1:0]    a_addr;
  logic [RowW-1:0]    b_addr;
  logic [RowW-1:0]    op_row;
  logic [RowW-1:0]    op_col;
  logic               op_place;
  logic [DiagW-1:0]   li_c;
  logic [DiagW-1:0]   ri_c;
  logic [CostW-1:0]   rise;
  logic               keep;
  logic               sweep_last;
  logic               in_xfer;
  logic               out_free;
  logic               move_skip;
  logic [BsW-1:0]     bs_ext;
  logic [ActW-1:0]    act_clamp;
  logic [CostExtW-1:0] cost_ext;
  logic [COST_W-1:0]  cost_sat;
  logic [ColExtW-1:0] col_out_ext;
  action_e            in_action;

  assign in_action = action_e'(in_ch.action);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !res_valid_q || out_ch.ready;

  assign a_ext  = RowExtW'(a_q);
  assign b_ext  = RowExtW'(b_q);
  assign a_addr = a_ext[RowW-1:0];
  assign b_addr = b_ext[RowW-1:0];

  // The board size is saturated into the legal range when a start latches it.
  assign bs_ext    = BsW'(board_size_q);
  assign act_clamp = (bs_ext < BsW'(4)) ? ActW'(4) :
                     (bs_ext > BsW'(MAX_QUEENS)) ? ActW'(MAX_QUEENS) : ActW'(bs_ext);

  // A move does nothing before the first start, once solved, on equal rows, or
  // when either row lies outside the active board.
  assign move_skip = !loaded_q || solved_q || (in_ch.first_row == in_ch.second_row) ||
                     (CmpW'(in_ch.first_row) >= CmpW'(act_q)) ||
                     (CmpW'(in_ch.second_row) >= CmpW'(act_q));

  assign sweep_last = (sweep_q == SweepW'(2 * MAX_QUEENS - 1));

  // The four counter steps of a swap: lift a, lift b, place a, place b. Row a
  // holds its old column in the first step and the other column in the third;
  // the undo pass runs the same steps with the two columns exchanged.
  assign op_row   = op_q[0] ? b_addr : a_addr;
  assign op_col   = (((op_q == 2'd0) || (op_q == 2'd3)) ^ undo_q) ? ca_q : cb_q;
  assign op_place = op_q[1];
  assign li_c = DiagW'((DiagW + 1)'(act_q) + (DiagW + 1)'(op_row) - (DiagW + 1)'(op_col));
  assign ri_c = DiagW'((DiagW + 1)'(op_row) + (DiagW + 1)'(op_col));

  // Annealing test: keep a falling cost, a zero sample, or an uphill move when
  // T * |ln(sample/1000)| in Q32.32 beats the rise.
  assign rise = work_cost_q - cost_q;
  assign keep = (work_cost_q < cost_q) || (sample_q == '0) ||
                ((sample_q < SAMPLE_ONE) && (64'(prod_q) > (64'(rise) << 32)));

  assign cost_ext    = CostExtW'(cost_q);
  assign cost_sat    = (cost_ext > CostExtW'(COST_SAT)) ? COST_SAT : cost_ext[COST_W-1:0];
  assign col_out_ext = ColExtW'(res_col_q);

  assign in_ch.ready     = (state_q == ST_IDLE);
  assign out_ch.valid    = res_valid_q;
  assign out_ch.cost     = res_cost_q;
  assign out_ch.accepted = res_acc_q;
  assign out_ch.skipped  = res_skip_q;
  assign out_ch.solved   = res_solved_q;
  assign out_ch.column   = col_out_ext[COL_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = start_flag_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_action)
            ACT_START: state_d = ST_SWEEP;
            ACT_MOVE:  state_d = move_skip ? ST_DONE : ST_COLA;
            ACT_READ:  state_d = ST_ROWRD;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_COLA:   state_d = ST_COLB;
      ST_COLB:   state_d = ST_CAPB;
      ST_CAPB:   state_d = ST_OPRD;
      ST_OPRD:   state_d = ST_OPWR;
      ST_OPWR: begin
        if (op_q == 2'd3) state_d = undo_q ? ST_DONE : ST_MUL;
        else              state_d = ST_OPRD;
      end
      ST_MUL:    state_d = ST_DECIDE;
      ST_DECIDE: state_d = keep ? ST_WRA : ST_OPRD;
      ST_WRA:    state_d = ST_WRB;
      ST_WRB:    state_d = ST_DONE;
      ST_ROWRD:  state_d = ST_ROWCAP;
      ST_ROWCAP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    col_we    = 1'b0;
    col_waddr = sweep_q[RowW-1:0];
    col_wdata = sweep_q[RowW-1:0];
    col_raddr = a_addr;
    ld_we     = 1'b0;
    ld_waddr  = li_q;
    ld_wdata  = op_place ? (ld_rd_q + 1'b1) : (ld_rd_q - 1'b1);
    ld_raddr  = li_c;
    rd_we     = 1'b0;
    rd_waddr  = ri_q;
    rd_wdata  = op_place ? (rd_rd_q + 1'b1) : (rd_rd_q - 1'b1);
    rd_raddr  = ri_c;
    case (state_q)
      ST_SWEEP: begin
        // All queens of the identity board share one left diagonal and sit on
        // the even right diagonals.
        col_we   = (sweep_q < SweepW'(MAX_QUEENS));
        ld_we    = 1'b1;
        ld_waddr = sweep_q[DiagW-1:0];
        ld_wdata = (sweep_q == SweepW'(act_q)) ? CntW'(act_q) : '0;
        rd_we    = 1'b1;
        rd_waddr = sweep_q[DiagW-1:0];
        rd_wdata = (!sweep_q[0] && ((sweep_q >> 1) < SweepW'(act_q))) ? CntW'(1) : '0;
      end
      ST_COLB: col_raddr = b_addr;
      ST_OPWR: begin
        ld_we = 1'b1;
        rd_we = 1'b1;
      end
      ST_WRA: begin
        col_we    = 1'b1;
        col_waddr = a_addr;
        col_wdata = cb_q;
      end
      ST_WRB: begin
        col_we    = 1'b1;
        col_waddr = b_addr;
        col_wdata = ca_q;
      end
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rd_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) ld_mem[ld_waddr] <= ld_wdata;
    ld_rd_q <= ld_mem[ld_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rd_we) rd_mem[rd_waddr] <= rd_wdata;
    rd_rd_q <= rd_mem[rd_raddr];
  end

  always_ff @(posedge clk_i) begin
    ln_q <= LnRom[sample_q];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= BOARD_SIZE_RESET;
      start_temp_q <= START_TEMP_RESET;
      cooling_q    <= COOLING_RESET;
      state_q      <= ST_SWEEP;
      sweep_q      <= '0;
      start_flag_q <= 1'b0;
      loaded_q     <= 1'b0;
      solved_q     <= 1'b0;
      act_q        <= ActW'(ActReset);
      cost_q       <= '0;
      temp_q       <= START_TEMP_RESET;
      op_q         <= '0;
      undo_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOARD_SIZE: board_size_q <= cfg_data_i[BOARD_W-1:0];
          CFG_START_TEMP: start_temp_q <= cfg_data_i[TEMP_W-1:0];
          CFG_COOLING:    cooling_q    <= cfg_data_i[COOL_W-1:0];
          default: ;
        endcase
      end

      state_q <= state_d;

      // The result register fills from the done state and empties on a transfer out.
      if ((state_q == ST_DONE) && out_free) res_valid_q <= 1'b1;
      else if (out_ch.ready)                res_valid_q <= 1'b0;

      case (state_q)
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_last && start_flag_q) begin
            cost_q   <= CostW'(CostW'(act_q) * CostW'(act_q - 1'b1));
            temp_q   <= start_temp_q;
            solved_q <= 1'b0;
            loaded_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_xfer && (in_action == ACT_START)) begin
            sweep_q      <= '0;
            start_flag_q <= 1'b1;
            act_q        <= act_clamp;
          end
          op_q   <= '0;
          undo_q <= 1'b0;
        end
        ST_OPWR: begin
          op_q <= op_q + 1'b1;
          if ((op_q == 2'd3) && undo_q && (cost_q == '0)) solved_q <= 1'b1;
        end
        ST_DECIDE: begin
          temp_q <= cool_q[CoolPrW-1:COOL_W];
          if (keep) begin
            cost_q <= work_cost_q;
            if (work_cost_q == '0) solved_q <= 1'b1;
          end else begin
            undo_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          a_q       <= in_ch.first_row;
          b_q       <= in_ch.second_row;
          sample_q  <= in_ch.random_sample;
          rd_ok_q   <= (CmpW'(in_ch.first_row) < CmpW'(MAX_QUEENS));
          acc_q     <= 1'b0;
          skip_q    <= (in_action == ACT_NOP) || ((in_action == ACT_MOVE) && move_skip);
          col_res_q <= '0;
        end
      end
      ST_COLB: ca_q <= col_rd_q;
      ST_CAPB: begin
        cb_q        <= col_rd_q;
        work_cost_q <= cost_q;
      end
      ST_OPRD: begin
        li_q <= li_c;
        ri_q <= ri_c;
      end
      ST_OPWR: begin
        if (op_place) begin
          work_cost_q <= work_cost_q + (CostW'(ld_rd_q) << 1) + (CostW'(rd_rd_q) << 1);
        end else begin
          work_cost_q <= work_cost_q - (CostW'(ld_rd_q - 1'b1) << 1)
                                     - (CostW'(rd_rd_q - 1'b1) << 1);
        end
      end
      ST_MUL: begin
        prod_q <= PrW'(temp_q) * PrW'(ln_q);
        cool_q <= CoolPrW'(temp_q) * CoolPrW'(cooling_q);
      end
      ST_DECIDE: acc_q <= keep;
      ST_ROWCAP: col_res_q <= rd_ok_q ? col_rd_q : '0;
      ST_DONE: begin
        if (out_free) begin
          res_cost_q   <= cost_sat;
          res_acc_q    <= acc_q;
          res_skip_q   <= skip_q;
          res_solved_q <= solved_q;
          res_col_q    <= col_res_q;
        end
      end
      default: ;
    endcase
  end

`include "nqueens_annealing_swap_engine_macros.svh"

  `NQAS_ASSERT_NOW(a_acc_skip_excl, res_valid_q, !(res_acc_q && res_skip_q), "kept and skipped")
  `NQAS_ASSERT_NOW(a_zero_cost_solved, (state_q == ST_IDLE) && loaded_q && (cost_q == '0), solved_q, "zero cost without solved")
  `NQAS_ASSERT_NEXT(a_undo_restores, (state_q == ST_OPWR) && undo_q && (op_q == 2'd3), work_cost_q == cost_q, "undo did not restore cost")
  `NQAS_ASSERT_NOW(a_rows_distinct, state_q == ST_OPRD, a_addr != b_addr, "swap on equal rows")

endmodule

`default_nettype wire
